### design/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared widths, sizes and the command record passed from the front end
// to the back end of the byte stream reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int IDX_W        = 32;  // stream position width
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 7;   // counts and windows up to 64
    localparam int SLOT_COUNT   = 64;  // reassembly store depth
    localparam int SLOT_W       = 6;   // index into the store
    localparam int DEF_CAPACITY = 64;  // default receive capacity

    // One classified input item, as queued between front and back.
    typedef struct packed {
        logic [IDX_W-1:0]  stream_index;
        logic [BYTE_W-1:0] data_byte;
        logic              has_data;
        logic              eof_here;
        logic [CNT_W-1:0]  window;     // free window for this item
    } t_cmd;

endpackage

### design/bsr_if.sv
// ----------------------------------------------------------------------------
// bsr_if
// Valid/ready channels for input items and for delivered results.
// ----------------------------------------------------------------------------
interface bsr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        eof_here;
    logic [6:0]  downstream_used;

    modport source (
        output valid, stream_index, data_byte, has_data, eof_here, downstream_used,
        input  ready
    );
    modport sink (
        input  valid, stream_index, data_byte, has_data, eof_here, downstream_used,
        output ready
    );
endinterface

interface bsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_ended;
    logic [6:0] unassembled_count;

    modport source (
        output valid, out_byte, byte_valid, run_last, stream_ended, unassembled_count,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, run_last, stream_ended, unassembled_count,
        output ready
    );
endinterface

### design/byte_stream_reassembler.sv
// ----------------------------------------------------------------------------
// byte_stream_reassembler
// Out-of-order byte stream reassembly with in-order delivery.
// ----------------------------------------------------------------------------
// Usage: each transaction on i_in carries one byte with its absolute stream
// position (or a bare end mark), plus the current downstream fill level.
// Bytes inside the free window are kept in a 64-slot store; duplicates and
// bytes outside the window are dropped. Each input transaction produces one
// or more result transactions on o_out: one per byte that became
// contiguous at the head, in order, or a single empty result when nothing
// was delivered. run_last flags the final result of each input item.
// Timing: each item is popped from the queue and then stored; an item that
// delivers nothing gets its empty result from the store step, and each byte
// released is read through the slot memory's registered read port, then sent.
// A two-entry queue lets the input side keep taking items while the back
// end drains, and an output register holds a result while o_out stalls;
// a stalled receiver simply freezes the drain sequencer in place.
// Reset clears all valid bits, the head, the positions and the counters;
// the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module byte_stream_reassembler #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsr_in_if.sink    i_in,
    bsr_out_if.source o_out
);
    import bsr_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Front end: takes input transactions and computes the receive window.
    bsr_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: stores bytes and drains the contiguous head in order.
    bsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

    // An empty result is always the only result of its item.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.byte_valid |-> o_out.run_last)
        else $error("empty result not marked as last");

    // The store never holds more bytes than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.unassembled_count <= 7'd64)
        else $error("unassembled count above store size");

    // Delivering a byte frees a slot, so a full store cannot remain.
    a_delivery_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.byte_valid |-> o_out.unassembled_count < 7'd64)
        else $error("count not reduced by delivery");

endmodule

### design/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front
// Accepts input items, works out the free receive window and queues the
// classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bsr_front #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsr_in_if.sink        i_in,
    output bsr_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    import bsr_pkg::*;

    localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

    t_cmd       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       in_cmd;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;

    always_comb begin
        in_cmd.stream_index = i_in.stream_index;
        in_cmd.data_byte    = i_in.data_byte;
        in_cmd.has_data     = i_in.has_data;
        in_cmd.eof_here     = i_in.eof_here;
        // A downstream fill at or above capacity closes the window.
        if (i_in.downstream_used >= Cap) begin
            in_cmd.window = '0;
        end else begin
            in_cmd.window = Cap - i_in.downstream_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    assign o_cmd       = r_q[r_rptr];
    assign o_cmd_valid = (r_cnt != 2'd0);

endmodule

### design/bsr_back.sv
// ----------------------------------------------------------------------------
// bsr_back
// Executes queued items: window check, duplicate check, store into the
// slot memory, end-mark tracking and in-order draining into a registered
// output stage.
// ----------------------------------------------------------------------------
module bsr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsr_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    bsr_out_if.source     o_out
);
    import bsr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STORE = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              stream_ended;
        logic [CNT_W-1:0]  unassembled_count;
    } t_res;

    logic [BYTE_W-1:0]     r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [2:0]            r_state, n_state;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic [IDX_W-1:0]      r_ne, n_ne;
    logic [IDX_W-1:0]      r_end, n_end;
    logic                  r_known, n_known;
    logic [CNT_W-1:0]      r_pending, n_pending;
    logic                  r_ov, n_ov;
    t_res                  r_res, n_res;

    // Latched classification of the item being executed.
    logic [BYTE_W-1:0]     r_data;
    logic                  r_store_ok, n_store_ok;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_at_head, n_at_head;
    logic [BYTE_W-1:0]     r_rd_data;

    logic [IDX_W-1:0]      offset;
    logic                  out_free, is_new, drain, last, mem_we, rd_en;
    logic [SLOT_W-1:0]     head_nxt;

    assign out_free = !r_ov || o_out.ready;
    assign is_new   = r_store_ok && !r_valid[r_slot];
    assign drain    = r_store_ok && r_at_head;
    assign head_nxt = r_head + 1'b1;
    assign offset   = i_cmd.stream_index - r_ne;

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_head     = r_head;
        n_ne       = r_ne;
        n_end      = r_end;
        n_known    = r_known;
        n_pending  = r_pending;
        n_ov       = r_ov && !o_out.ready;
        n_res      = r_res;
        n_store_ok = i_cmd.has_data && (offset < {{(IDX_W-CNT_W){1'b0}}, i_cmd.window});
        n_slot     = r_head + offset[SLOT_W-1:0];
        n_at_head  = (offset == '0);
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        last       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.eof_here) begin
                        n_end   = i_cmd.stream_index + {{(IDX_W-1){1'b0}}, i_cmd.has_data};
                        n_known = 1'b1;
                    end
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                // The head slot is always empty between items, so a byte
                // stored at the head starts a drain run.
                if (drain) begin
                    mem_we           = is_new;
                    n_valid[r_slot]  = 1'b1;
                    n_pending        = r_pending + 1'b1;
                    n_state          = S_RD;
                end else if (out_free) begin
                    mem_we = is_new;
                    if (is_new) begin
                        n_valid[r_slot] = 1'b1;
                        n_pending       = r_pending + 1'b1;
                    end
                    n_ov                    = 1'b1;
                    n_res.out_byte          = '0;
                    n_res.byte_valid        = 1'b0;
                    n_res.run_last          = 1'b1;
                    n_res.stream_ended      = r_known && (r_ne == r_end);
                    n_res.unassembled_count = n_pending;
                    n_state                 = S_IDLE;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    last             = !r_valid[head_nxt];
                    n_valid[r_head]  = 1'b0;
                    n_head           = head_nxt;
                    n_ne             = r_ne + 1'b1;
                    if (r_pending != '0) begin
                        n_pending = r_pending - 1'b1;
                    end
                    n_ov                    = 1'b1;
                    n_res.out_byte          = r_rd_data;
                    n_res.byte_valid        = 1'b1;
                    n_res.run_last          = last;
                    n_res.stream_ended      = r_known && (n_ne == r_end);
                    n_res.unassembled_count = n_pending;
                    n_state                 = last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= r_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (o_cmd_pop) begin
            r_data     <= i_cmd.data_byte;
            r_store_ok <= n_store_ok;
            r_slot     <= n_slot;
            r_at_head  <= n_at_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_head    <= '0;
            r_ne      <= '0;
            r_end     <= '0;
            r_known   <= 1'b0;
            r_pending <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_head    <= n_head;
            r_ne      <= n_ne;
            r_end     <= n_end;
            r_known   <= n_known;
            r_pending <= n_pending;
            r_ov      <= n_ov;
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.out_byte          = r_res.out_byte;
    assign o_out.byte_valid        = r_res.byte_valid;
    assign o_out.run_last          = r_res.run_last;
    assign o_out.stream_ended      = r_res.stream_ended;
    assign o_out.unassembled_count = r_res.unassembled_count;

endmodule
